// ===== src/mstw_pkg.sv =====
// ----------------------------------------------------------------------------
// mstw_pkg
// Types and constants shared by the minimum spanning tree weight block.
// ----------------------------------------------------------------------------
package mstw_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int MAX_EDGES    = 64;
	localparam int WEIGHT_BITS  = 16;

	localparam int VERTEX_W = 4;
	localparam int IN_W     = 16;
	localparam int TOTAL_W  = 20;
	localparam int VCOUNT_W = 5;
	localparam int VIDX_W   = $clog2(MAX_VERTICES);
	localparam int NV_W     = $clog2(MAX_VERTICES + 1);
	localparam int COUNT_W  = $clog2(MAX_EDGES + 1);

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(16);
	localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = {TOTAL_W{1'b1}};

	typedef struct packed {
		logic [VERTEX_W-1:0] edge_from;
		logic [VERTEX_W-1:0] edge_to;
		logic [IN_W-1:0]     edge_weight;
		logic                last_edge;
	} mstw_in_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] tree_weight;
		logic               connected;
		logic               overflowed;
	} mstw_out_t;

	typedef struct packed {
		logic                   v;
		logic [VERTEX_W-1:0]    from;
		logic [VERTEX_W-1:0]    to;
		logic [WEIGHT_BITS-1:0] weight;
	} mstw_slot_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} mstw_sort_ctrl_t;

	typedef struct packed {
		logic                clear;
		logic                step;
		logic [VERTEX_W-1:0] from;
		logic [VERTEX_W-1:0] to;
		logic [NV_W-1:0]     nv;
	} mstw_uf_ctrl_t;

endpackage

// ===== src/mstw_cell.sv =====
// ----------------------------------------------------------------------------
// mstw_cell
// One sorter cell: keeps the lighter edge, hands the heavier one on; a shift loads the neighbour's edge.
// ----------------------------------------------------------------------------
module mstw_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mstw_pkg::mstw_sort_ctrl_t ctrl,
	input  mstw_pkg::mstw_slot_t     left_pass,
	input  mstw_pkg::mstw_slot_t     right_hold,
	output mstw_pkg::mstw_slot_t     hold,
	output mstw_pkg::mstw_slot_t     pass
);
	import mstw_pkg::*;

	mstw_slot_t hold_q, pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			pass_q <= '0;
		end else if (ctrl.clear) begin
			hold_q <= '0;
			pass_q <= '0;
		end else if (ctrl.shift) begin
			hold_q   <= right_hold;
			pass_q.v <= 1'b0;
		end else if (left_pass.v && hold_q.v) begin
			if (left_pass.weight < hold_q.weight) begin
				hold_q <= left_pass;
				pass_q <= hold_q;
			end else begin
				pass_q <= left_pass;
			end
		end else begin
			pass_q.v <= 1'b0;
			if (left_pass.v) hold_q <= left_pass;
		end
	end

	assign hold = hold_q;
	assign pass = pass_q;

endmodule

// ===== src/mstw_sorter.sv =====
// ----------------------------------------------------------------------------
// mstw_sorter
// Chain of insertion cells; ascending weight order, shift-out from cell 0.
// ----------------------------------------------------------------------------
module mstw_sorter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mstw_pkg::mstw_sort_ctrl_t ctrl,
	input  mstw_pkg::mstw_slot_t      ins,
	output mstw_pkg::mstw_slot_t      head,
	output logic                      busy
);
	import mstw_pkg::*;

	mstw_slot_t hold_w [MAX_EDGES];
	mstw_slot_t pass_w [MAX_EDGES];
	logic [MAX_EDGES-1:0] pass_v;

	for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
		mstw_slot_t left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = ins;
		end else begin : g_mid
			assign left_w = pass_w[i-1];
		end
		if (i == MAX_EDGES - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = hold_w[i+1];
		end
		mstw_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left_pass  (left_w),
			.right_hold (right_w),
			.hold       (hold_w[i]),
			.pass       (pass_w[i])
		);
		assign pass_v[i] = pass_w[i].v;
	end

	assign head = hold_w[0];
	assign busy = |pass_v;

endmodule

// ===== src/mstw_uf.sv =====
// ----------------------------------------------------------------------------
// mstw_uf
// Component labels per vertex; an accepted step merges the two components of an edge.
// ----------------------------------------------------------------------------
module mstw_uf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mstw_pkg::mstw_uf_ctrl_t ctrl,
	output logic                    accept
);
	import mstw_pkg::*;

	logic [VIDX_W-1:0] label_q [MAX_VERTICES];
	logic [VIDX_W-1:0] la, lb;
	logic              in_range;

	assign la       = label_q[ctrl.from[VIDX_W-1:0]];
	assign lb       = label_q[ctrl.to[VIDX_W-1:0]];
	assign in_range = (NV_W'(ctrl.from) < ctrl.nv) && (NV_W'(ctrl.to) < ctrl.nv);
	assign accept   = ctrl.step && in_range && (la != lb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < MAX_VERTICES; v++) label_q[v] <= VIDX_W'(v);
		end else if (ctrl.clear) begin
			for (int v = 0; v < MAX_VERTICES; v++) label_q[v] <= VIDX_W'(v);
		end else if (accept) begin
			for (int v = 0; v < MAX_VERTICES; v++) begin
				if (label_q[v] == la) label_q[v] <= lb;
			end
		end
	end

endmodule

// ===== src/minimum_spanning_tree_weight.sv =====
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight
// Loads edges into a sorting cell chain, then scans them lightest first and
// merges components, emitting the spanning tree weight.
// ----------------------------------------------------------------------------
//  channel  dir  payload     request
//  item     in   mstw_in_t   one edge
//  result   out  mstw_out_t  weight and flags
//  cfg      in   5 bits      vertex_count
//
//  Edges load one per cycle in ST_LOAD. After the last edge the chain settles
//  until no cell hands an edge on, then one stored edge is scanned per cycle until
//  the tree is complete or the list ends. No clearing pass after reset. The next
//  graph loads while a result waits; a finished scan holds until it is taken.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_weight (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  mstw_pkg::mstw_in_t            item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output mstw_pkg::mstw_out_t           result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mstw_pkg::VCOUNT_W-1:0] cfg_data
);
	import mstw_pkg::*;

	typedef enum logic [1:0] {ST_LOAD, ST_DRAIN, ST_SCAN} state_t;

	state_t                state_q;
	logic [VCOUNT_W-1:0]   vcount_q;
	logic [COUNT_W-1:0]    loaded_q, remaining_q;
	logic                  overflow_q;
	logic [NV_W-1:0]       nv_q;
	logic [VIDX_W-1:0]     accepted_q, need_q;
	logic [TOTAL_W-1:0]    total_q;
	logic                  out_valid_q;
	mstw_out_t             out_q;

	mstw_sort_ctrl_t       sort_ctrl;
	mstw_slot_t            ins, head;
	logic                  busy;
	mstw_uf_ctrl_t         uf_ctrl;
	logic                  uf_accept;

	logic                  take, room, done, finish, scan_step;
	logic [NV_W-1:0]       nv_clamp;
	logic [TOTAL_W:0]      sum;

	assign item_ready   = (state_q == ST_LOAD);
	assign cfg_ready    = 1'b1;
	assign take         = item_valid && item_ready;
	assign room         = (loaded_q < COUNT_W'(MAX_EDGES));
	assign done         = (accepted_q == need_q) || (remaining_q == '0);
	assign finish       = (state_q == ST_SCAN) && done && !out_valid_q;
	assign scan_step    = (state_q == ST_SCAN) && !done;

	always_comb begin
		if (vcount_q < VCOUNT_W'(2))                 nv_clamp = NV_W'(2);
		else if (vcount_q > VCOUNT_W'(MAX_VERTICES)) nv_clamp = NV_W'(MAX_VERTICES);
		else                                         nv_clamp = NV_W'(vcount_q);
	end

	assign ins.v      = take && room;
	assign ins.from   = item.edge_from;
	assign ins.to     = item.edge_to;
	assign ins.weight = item.edge_weight[WEIGHT_BITS-1:0];

	assign sort_ctrl.clear = finish;
	assign sort_ctrl.shift = scan_step;

	assign uf_ctrl.clear = finish;
	assign uf_ctrl.step  = scan_step;
	assign uf_ctrl.from  = head.from;
	assign uf_ctrl.to    = head.to;
	assign uf_ctrl.nv    = nv_q;

	assign sum = {1'b0, total_q} + (TOTAL_W+1)'(head.weight);

	mstw_sorter u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (sort_ctrl),
		.ins    (ins),
		.head   (head),
		.busy   (busy)
	);

	mstw_uf u_uf (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (uf_ctrl),
		.accept (uf_accept)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			vcount_q    <= VCOUNT_RESET;
			loaded_q    <= '0;
			remaining_q <= '0;
			overflow_q  <= 1'b0;
			nv_q        <= NV_W'(MAX_VERTICES);
			accepted_q  <= '0;
			need_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) vcount_q <= cfg_data;
			if (result_valid && result_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (take) begin
						if (room) loaded_q <= loaded_q + COUNT_W'(1);
						else      overflow_q <= 1'b1;
						if (item.last_edge) begin
							remaining_q <= room ? loaded_q + COUNT_W'(1) : loaded_q;
							nv_q        <= nv_clamp;
							need_q      <= VIDX_W'(nv_clamp - NV_W'(1));
							state_q     <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!busy) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (finish) begin
						out_q.tree_weight <= total_q;
						out_q.connected   <= (accepted_q == need_q);
						out_q.overflowed  <= overflow_q;
						out_valid_q       <= 1'b1;
						loaded_q          <= '0;
						overflow_q        <= 1'b0;
						accepted_q        <= '0;
						total_q           <= '0;
						state_q           <= ST_LOAD;
					end else if (scan_step) begin
						remaining_q <= remaining_q - COUNT_W'(1);
						if (uf_accept) begin
							accepted_q <= accepted_q + VIDX_W'(1);
							total_q    <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef NO_ASSERTIONS
	a_ready_only_load: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> state_q == ST_LOAD)
		else $error("item_ready outside load");
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		scan_step |-> head.v)
		else $error("scan reads an empty cell");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> accepted_q <= need_q)
		else $error("accepted edges exceed need");
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> result_valid && state_q == ST_LOAD && loaded_q == '0)
		else $error("result not posted on finish");
`endif

endmodule

// ===== tb/minimum_spanning_tree_weight_tb.sv =====
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight_tb
// Streams a directed table of edge lists, then random graphs, into the block;
// checks the table's graphs against their listed results and the random ones
// against its own Kruskal model, in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_weight_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mstw_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 2 * MAX_EDGES + 20;
	localparam int NRAND = 1130;

	typedef struct {
		logic [VERTEX_W-1:0]    from;
		logic [VERTEX_W-1:0]    to;
		logic [WEIGHT_BITS-1:0] weight;
		logic                   last;
		logic                   fixed;
		mstw_out_t              want;
	} edge_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	mstw_in_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	mstw_out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [4:0] cfg_data = '0;

	mstw_slot_t graph_edges[$];
	logic       graph_overflow;
	logic [4:0] vcount_reg;
	mstw_out_t  pending_trees[$];
	mstw_out_t  pinned_trees[$];
	logic       pinned_flag[$];
	int  errors = 0;
	int  idle_cycles = 0;
	bit  no_idle = 1'b0;
	bit  hold_results = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_len = 0;

	minimum_spanning_tree_weight DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic mstw_out_t kruskal_tree();
		mstw_slot_t sorted[$];
		logic [VERTEX_W-1:0] parent[MAX_VERTICES];
		int nv, need, taken, ra, rb;
		logic [TOTAL_W:0] total;
		mstw_out_t r;
		nv = vcount_reg < 2 ? 2 : (vcount_reg > MAX_VERTICES ? MAX_VERTICES : vcount_reg);
		need = nv - 1;
		taken = 0;
		total = '0;
		for (int v = 0; v < MAX_VERTICES; v++)
			parent[v] = VERTEX_W'(v);
		foreach (graph_edges[i]) begin
			int b;
			b = sorted.size();
			while (b > 0 && sorted[b-1].weight > graph_edges[i].weight)
				b--;
			sorted.insert(b, graph_edges[i]);
		end
		foreach (sorted[k]) begin
			if (taken >= need)
				break;
			if (sorted[k].from >= nv || sorted[k].to >= nv)
				continue;
			ra = sorted[k].from;
			for (int s = 0; s < MAX_VERTICES && parent[ra] != ra; s++)
				ra = parent[ra];
			rb = sorted[k].to;
			for (int s = 0; s < MAX_VERTICES && parent[rb] != rb; s++)
				rb = parent[rb];
			if (ra != rb) begin
				total = total + sorted[k].weight;
				if (total > TOTAL_MAX)
					total = TOTAL_MAX;
				taken++;
				parent[ra] = VERTEX_W'(rb);
			end
		end
		r.tree_weight = total[TOTAL_W-1:0];
		r.connected = (taken == need);
		r.overflowed = graph_overflow;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic idle_burst();
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic send_edge(input logic [3:0] f, input logic [3:0] t,
			input logic [15:0] w, input logic last, input logic fixed, input mstw_out_t want);
		mstw_slot_t s;
		item_valid <= 1'b1;
		item <= '{edge_from: f, edge_to: t, edge_weight: w, last_edge: last};
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		s = '{v: 1'b1, from: f, to: t, weight: w};
		if (graph_edges.size() < MAX_EDGES)
			graph_edges = {graph_edges, s};
		else
			graph_overflow = 1'b1;
		if (last) begin
			pending_trees = {pending_trees, kruskal_tree()};
			pinned_trees = {pinned_trees, want};
			pinned_flag = {pinned_flag, fixed};
			graph_edges.delete();
			graph_overflow = 1'b0;
		end
		idle_burst();
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_trees.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_vcount(input logic [4:0] v);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		vcount_reg = v;
	endtask

	task automatic random_graph(input int n, input int wmax);
		for (int i = 0; i < n; i++)
			send_edge(VERTEX_W'($urandom_range(0, 15)), VERTEX_W'($urandom_range(0, 15)),
				16'($urandom_range(0, wmax)), i == n - 1, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		if (hold_len > 0) begin
			hold_len <= hold_len - 1;
			result_ready <= 1'b0;
		end else if (hold_results && !hold_done) begin
			hold_done <= 1'b1;
			hold_len <= 299;
			result_ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 4) == 0) begin
			hold_len <= $urandom_range(0, 7);
			result_ready <= 1'b0;
		end else
			result_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_trees.size() == 0) begin
				report_mismatch("result count", 1, 0);
			end else begin
				mstw_out_t w;
				w = pending_trees.pop_front();
				if (pinned_flag.pop_front())
					w = pinned_trees.pop_front();
				else
					void'(pinned_trees.pop_front());
				if (result.tree_weight !== w.tree_weight)
					report_mismatch("tree_weight", result.tree_weight, w.tree_weight);
				if (result.connected !== w.connected)
					report_mismatch("connected", result.connected, w.connected);
				if (result.overflowed !== w.overflowed)
					report_mismatch("overflowed", result.overflowed, w.overflowed);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	edge_row_t directed[12];

	initial begin
		int sent;
		graph_overflow = 1'b0;
		vcount_reg = VCOUNT_RESET;
		// directed graphs, first a triangle on 0..2; vertex count 3 after reset write
		directed = '{
			'{0, 1, 5, 0, 0, '0}, '{1, 2, 3, 0, 0, '0}, '{0, 2, 1, 1, 1, '{4, 1, 0}},
			'{0, 1, 16'hFFFF, 0, 0, '0}, '{1, 2, 16'hFFFF, 1, 1, '{20'h1FFFE, 1, 0}},
			'{2, 2, 7, 0, 0, '0}, '{0, 15, 9, 0, 0, '0}, '{0, 1, 0, 1, 1, '{0, 0, 0}},
			'{1, 0, 2, 0, 0, '0}, '{2, 1, 2, 0, 0, '0}, '{0, 2, 0, 1, 1, '{2, 1, 0}},
			'{0, 0, 0, 1, 1, '{0, 0, 0}}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_vcount(5'd3);
		foreach (directed[i])
			send_edge(directed[i].from, directed[i].to, directed[i].weight,
				directed[i].last, directed[i].fixed, directed[i].want);
		write_vcount(5'd16);
		for (int i = 0; i < 16; i++)
			send_edge(VERTEX_W'(i), VERTEX_W'((i + 1) % 16), 16'hFFFF, i == 15, 1'b1,
				'{i == 15 ? 20'hEFFF1 : 20'h0, 1, 0});
		sent = 16;
		// overflow: more edges than the MAX_EDGES-slot store holds
		random_graph(70, 65535);
		sent += 70;
		write_vcount(5'd0);
		random_graph(4, 65535);
		write_vcount(5'd31);
		random_graph(30, 65535);
		write_vcount(5'd2);
		random_graph(6, 65535);
		sent += 40;
		// long stall on the result side while edges keep arriving
		hold_results = 1'b1;
		random_graph(20, 100);
		random_graph(20, 100);
		sent += 40;
		wait_drained();
		while (sent < NRAND) begin
			int n;
			if ($urandom_range(0, 9) == 0)
				write_vcount(5'($urandom_range(0, 31)));
			n = $urandom_range(0, 7) == 0 ? $urandom_range(40, 70) : $urandom_range(1, 18);
			if (sent > NRAND - 100)
				no_idle = 1'b1;
			random_graph(n, $urandom_range(0, 1) ? 65535 : 15);
			sent += n;
		end
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
src/mstw_pkg.sv
src/mstw_cell.sv
src/mstw_sorter.sv
src/mstw_uf.sv
src/minimum_spanning_tree_weight.sv
tb/minimum_spanning_tree_weight_tb.sv
